[sv/bfba_pkg.sv]
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared types and constants for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

    localparam logic [31:0] HEADER_BYTES = 32'd20;
    localparam logic [31:0] MIN_BLOCK    = 32'd16;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FAIL      = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;

    typedef logic [3:0] t_op;

    localparam t_op OP_NOP        = 4'd0;
    localparam t_op OP_ACCEPT     = 4'd1;
    localparam t_op OP_INIT       = 4'd2;
    localparam t_op OP_FAIL       = 4'd3;
    localparam t_op OP_SCAN_START = 4'd4;
    localparam t_op OP_SCAN       = 4'd5;
    localparam t_op OP_MOVE_UP    = 4'd6;
    localparam t_op OP_RD_NEXT    = 4'd7;
    localparam t_op OP_FNEXT      = 4'd8;
    localparam t_op OP_FMERGE     = 4'd9;
    localparam t_op OP_MOVE       = 4'd10;
    localparam t_op OP_WR_SPLIT   = 4'd11;
    localparam t_op OP_WR_ALLOC   = 4'd12;
    localparam t_op OP_LOAD_OUT   = 4'd13;

    typedef struct packed {
        logic is_init;
        logic is_alloc;
        logic is_free;
        logic early_fail;
        logic scan_done;
        logic found;
        logic hit;
        logic split;
        logic move_done;
        logic out_free;
    } t_dp_stat;

endpackage

[sv/bfba_if.sv]
// ----------------------------------------------------------------------------
// bfba_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface bfba_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] request_size;
    logic [31:0] free_address;

    modport source (output valid, cmd, request_size, free_address, input ready);
    modport sink   (input valid, cmd, request_size, free_address, output ready);
endinterface

interface bfba_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] payload_address;
    logic [31:0] used_bytes;
    logic [31:0] free_bytes;
    logic [6:0]  block_total;

    modport source (output valid, status, payload_address, used_bytes, free_bytes,
                    block_total, input ready);
    modport sink   (input valid, status, payload_address, used_bytes, free_bytes,
                    block_total, output ready);
endinterface

[sv/best_fit_block_allocator_unit.sv]
// init and rejected commands go from the prep state straight to the done state.
// allocate scans all N blocks, and on a split shifts M entries up and writes the split
// remainder before the allocated block; free scans to the hit at entry K, reads the next
// entry, merges and shifts M entries down; a miss of either kind fails after the scan.
// one item at a time: a new transfer in lands in the cycle after the result is loaded.
// reset empties the table (no clearing pass) and loads the register defaults.
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit
// Best-fit heap allocator with split and coalescing over a block table.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_unit
    import bfba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfba_in_if.sink     i_in,
    bfba_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0] r_heap_base;
    logic [31:0] r_heap_size;
    t_op         w_op;
    t_dp_stat    w_stat;

    // register index is the word address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= 32'd0;
            r_heap_size <= 32'd65536;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_heap_size <= pwdata;
            end else begin
                r_heap_base <= pwdata;
            end
        end
    end

    assign prdata = paddr[2] ? r_heap_size : r_heap_base;
    assign pready = 1'b1;

    bfba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .i_stat    (w_stat),
        .o_op      (w_op)
    );

    bfba_dp #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .o_stat           (w_stat),
        .i_heap_base      (r_heap_base),
        .i_heap_size      (r_heap_size),
        .i_cmd            (i_in.cmd),
        .i_request_size   (i_in.request_size),
        .i_free_address   (i_in.free_address),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_status         (o_out.status),
        .o_payload_address(o_out.payload_address),
        .o_used_bytes     (o_out.used_bytes),
        .o_free_bytes     (o_out.free_bytes),
        .o_block_total    (o_out.block_total)
    );
endmodule

[sv/bfba_ram.sv]
// ----------------------------------------------------------------------------
// bfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfba_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[sv/bfba_ctrl.sv]
// ----------------------------------------------------------------------------
// bfba_ctrl
// Command sequencer: scan, decide, shift and write back, then report.
// ----------------------------------------------------------------------------
module bfba_ctrl
    import bfba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_op      o_op
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PREP     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_DECIDE   = 4'd3;
    localparam logic [3:0] S_FNEXT    = 4'd4;
    localparam logic [3:0] S_FMERGE   = 4'd5;
    localparam logic [3:0] S_MOVE     = 4'd6;
    localparam logic [3:0] S_WR_SPLIT = 4'd7;
    localparam logic [3:0] S_WR_ALLOC = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_ACCEPT;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (i_stat.is_init) begin
                    o_op    = OP_INIT;
                    n_state = S_DONE;
                end else if (i_stat.early_fail) begin
                    o_op    = OP_FAIL;
                    n_state = S_DONE;
                end else begin
                    o_op    = OP_SCAN_START;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end else begin
                    o_op = OP_SCAN;
                end
            end
            S_DECIDE: begin
                if (i_stat.is_alloc) begin
                    if (!i_stat.found) begin
                        o_op    = OP_FAIL;
                        n_state = S_DONE;
                    end else if (i_stat.split) begin
                        o_op    = OP_MOVE_UP;
                        n_state = S_MOVE;
                    end else begin
                        n_state = S_WR_ALLOC;
                    end
                end else if (!i_stat.hit) begin
                    o_op    = OP_FAIL;
                    n_state = S_DONE;
                end else begin
                    o_op    = OP_RD_NEXT;
                    n_state = S_FNEXT;
                end
            end
            S_FNEXT: begin
                o_op    = OP_FNEXT;
                n_state = S_FMERGE;
            end
            S_FMERGE: begin
                o_op    = OP_FMERGE;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                if (i_stat.move_done) begin
                    n_state = i_stat.is_alloc ? S_WR_SPLIT : S_DONE;
                end else begin
                    o_op = OP_MOVE;
                end
            end
            S_WR_SPLIT: begin
                o_op    = OP_WR_SPLIT;
                n_state = S_WR_ALLOC;
            end
            S_WR_ALLOC: begin
                o_op    = OP_WR_ALLOC;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_op    = OP_LOAD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

[sv/bfba_dp.sv]
// ----------------------------------------------------------------------------
// bfba_dp
// Block table memory, scan and shift datapath, totals and result register.
// ----------------------------------------------------------------------------
module bfba_dp
    import bfba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    output t_dp_stat    o_stat,
    input  logic [31:0] i_heap_base,
    input  logic [31:0] i_heap_size,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_free_address,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_payload_address,
    output logic [31:0] o_used_bytes,
    output logic [31:0] o_free_bytes,
    output logic [6:0]  o_block_total
);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    // control state
    logic [CW-1:0] r_count;
    logic [31:0]   r_used;
    logic          r_out_valid;
    logic          r_dv;
    logic          r_hit;
    logic          r_found;
    logic [CW-1:0] r_mv_cnt;
    logic          r_mv_dv;

    // item and working registers
    logic [1:0]    r_cmd;
    logic [31:0]   r_req;
    logic [31:0]   r_faddr;
    logic [1:0]    r_status;
    logic [31:0]   r_addr;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_pidx;
    logic [31:0]   r_acc;
    logic [CW-1:0] r_best;
    logic [31:0]   r_best_len;
    logic [31:0]   r_best_addr;
    logic [CW-1:0] r_tidx;
    logic [31:0]   r_tlen;
    logic [31:0]   r_plen;
    logic          r_pfree;
    logic          r_mn;
    logic [CW-1:0] r_mv_src;
    logic [CW-1:0] r_mv_dst;
    logic          r_mv_up;
    logic [1:0]    r_mv_dist;

    // result register
    logic [1:0]    r_o_status;
    logic [31:0]   r_o_addr;
    logic [31:0]   r_o_used;
    logic [31:0]   r_o_free;
    logic [6:0]    r_o_total;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [32:0]   w_wr_data;
    logic [AW-1:0] w_rd_addr;
    logic [32:0]   w_rd_data;
    logic [31:0]   q_len;
    logic          q_free;
    logic          w_fit;
    logic          w_match;
    logic          w_split;
    logic          w_mp;
    logic          w_mn_now;
    logic [CW-1:0] w_fstart;
    logic [1:0]    w_fdist;
    logic [31:0]   w_alloc_len;

    bfba_ram #(
        .WIDTH(33),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign q_len  = w_rd_data[31:0];
    assign q_free = w_rd_data[32];

    assign w_fit   = q_free && (q_len >= r_req) && (!r_found || (q_len < r_best_len));
    assign w_match = !q_free && (r_acc == r_faddr);
    assign w_split = ({1'b0, r_best_len} > ({1'b0, r_req} + {1'b0, HEADER_BYTES}
                      + {1'b0, MIN_BLOCK})) && (r_count < MAX_CNT);
    assign w_mp     = (r_tidx != '0) && r_pfree;
    assign w_mn_now = ((r_tidx + ONE) < r_count) && q_free;
    assign w_fstart = r_tidx + ONE + CW'(r_mn);
    assign w_fdist  = 2'(r_mn) + 2'(w_mp);
    assign w_alloc_len = w_split ? r_req : r_best_len;

    always_comb begin
        o_stat.is_init    = (r_cmd == CMD_INIT);
        o_stat.is_alloc   = (r_cmd == CMD_ALLOC);
        o_stat.is_free    = (r_cmd == CMD_FREE);
        o_stat.early_fail = ((r_cmd != CMD_ALLOC) && (r_cmd != CMD_FREE)
                             && (r_cmd != CMD_INIT))
                            || ((r_cmd == CMD_ALLOC) && ((r_req == '0) || (r_count == '0)))
                            || ((r_cmd == CMD_FREE) && (r_count == '0));
        o_stat.scan_done  = r_hit || (!r_dv && (r_idx == r_count));
        o_stat.found      = r_found;
        o_stat.hit        = r_hit;
        o_stat.split      = w_split;
        o_stat.move_done  = (r_mv_cnt == '0) && !r_mv_dv;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // table read and write selection
    always_comb begin
        w_rd_addr = r_idx[AW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_mv_dst[AW-1:0];
        w_wr_data = w_rd_data;
        unique case (i_op)
            OP_INIT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
                w_wr_data = {1'b1, (i_heap_size > HEADER_BYTES) ?
                             (i_heap_size - HEADER_BYTES) : 32'd0};
            end
            OP_RD_NEXT: begin
                w_rd_addr = AW'(r_tidx + ONE);
            end
            OP_FMERGE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_mp ? AW'(r_tidx - ONE) : r_tidx[AW-1:0];
                w_wr_data = {1'b1, w_mp ? (r_plen + HEADER_BYTES + r_tlen) : r_tlen};
            end
            OP_MOVE: begin
                w_rd_addr = r_mv_src[AW-1:0];
                w_wr_en   = r_mv_dv;
            end
            OP_WR_SPLIT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = AW'(r_best + ONE);
                w_wr_data = {1'b1, r_best_len - r_req - HEADER_BYTES};
            end
            OP_WR_ALLOC: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_best[AW-1:0];
                w_wr_data = {1'b0, w_alloc_len};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
            r_hit       <= 1'b0;
            r_found     <= 1'b0;
            r_mv_cnt    <= '0;
            r_mv_dv     <= 1'b0;
        end else begin
            if (i_op == OP_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_op)
                OP_INIT: begin
                    r_count <= ONE;
                    r_used  <= '0;
                end
                OP_SCAN_START: begin
                    r_dv    <= 1'b0;
                    r_hit   <= 1'b0;
                    r_found <= 1'b0;
                end
                OP_SCAN: begin
                    r_dv <= (r_idx < r_count);
                    if (r_dv) begin
                        if (o_stat.is_free && w_match) begin
                            r_hit <= 1'b1;
                        end
                        if (o_stat.is_alloc && w_fit) begin
                            r_found <= 1'b1;
                        end
                    end
                end
                OP_MOVE_UP: begin
                    r_mv_cnt <= r_count - ONE - r_best;
                    r_mv_dv  <= 1'b0;
                end
                OP_FNEXT: begin
                    r_used <= r_used - HEADER_BYTES - r_tlen;
                end
                OP_FMERGE: begin
                    r_count  <= r_count - CW'(w_fdist);
                    r_mv_cnt <= r_count - w_fstart;
                    r_mv_dv  <= 1'b0;
                end
                OP_MOVE: begin
                    r_mv_dv <= (r_mv_cnt != '0);
                    if (r_mv_cnt != '0) begin
                        r_mv_cnt <= r_mv_cnt - ONE;
                    end
                end
                OP_WR_ALLOC: begin
                    r_used  <= r_used + HEADER_BYTES + w_alloc_len;
                    r_count <= r_count + CW'(w_split);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_ACCEPT: begin
                r_cmd   <= i_cmd;
                r_faddr <= i_free_address;
                r_addr  <= '0;
                if (i_request_size == '0) begin
                    r_req <= '0;
                end else if (i_request_size < MIN_BLOCK) begin
                    r_req <= MIN_BLOCK;
                end else begin
                    r_req <= i_request_size;
                end
            end
            OP_INIT: begin
                r_status <= STS_OK;
            end
            OP_FAIL: begin
                r_status <= (r_cmd == CMD_FREE) ? STS_NOT_FOUND : STS_FAIL;
            end
            OP_SCAN_START: begin
                r_idx   <= '0;
                r_acc   <= i_heap_base + HEADER_BYTES;
                r_pfree <= 1'b0;
            end
            OP_SCAN: begin
                if (r_idx < r_count) begin
                    r_idx  <= r_idx + ONE;
                    r_pidx <= r_idx;
                end
                if (r_dv && !r_hit) begin
                    r_acc <= r_acc + HEADER_BYTES + q_len;
                    if (o_stat.is_free && w_match) begin
                        r_tidx <= r_pidx;
                        r_tlen <= q_len;
                    end else begin
                        r_plen  <= q_len;
                        r_pfree <= q_free;
                    end
                    if (o_stat.is_alloc && w_fit) begin
                        r_best      <= r_pidx;
                        r_best_len  <= q_len;
                        r_best_addr <= r_acc;
                    end
                end
            end
            OP_MOVE_UP: begin
                r_mv_src <= r_count - ONE;
                r_mv_up  <= 1'b1;
            end
            OP_FNEXT: begin
                r_mn <= w_mn_now;
                if (w_mn_now) begin
                    r_tlen <= r_tlen + HEADER_BYTES + q_len;
                end
            end
            OP_FMERGE: begin
                r_status  <= STS_OK;
                r_mv_src  <= w_fstart;
                r_mv_up   <= 1'b0;
                r_mv_dist <= w_fdist;
            end
            OP_MOVE: begin
                if (r_mv_cnt != '0) begin
                    // up shifts walk down the table, down shifts walk up
                    r_mv_src <= r_mv_up ? (r_mv_src - ONE) : (r_mv_src + ONE);
                    r_mv_dst <= r_mv_up ? (r_mv_src + ONE) : (r_mv_src - CW'(r_mv_dist));
                end
            end
            OP_WR_ALLOC: begin
                r_status <= STS_OK;
                r_addr   <= r_best_addr;
            end
            OP_LOAD_OUT: begin
                r_o_status <= r_status;
                r_o_addr   <= r_addr;
                r_o_used   <= r_used;
                r_o_free   <= i_heap_size - r_used;
                r_o_total  <= 7'(r_count);
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_payload_address = r_o_addr;
    assign o_used_bytes      = r_o_used;
    assign o_free_bytes      = r_o_free;
    assign o_block_total     = r_o_total;
endmodule
